>>> src/gdf_pkg.sv
`default_nettype none

package gdf_pkg;

   localparam int YEAR_W    = 14;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int WDAY_W    = 3;
   localparam int DIM_W     = 5;
   localparam int DOY_W     = 9;
   localparam int SHIFT_W   = 15;   // year + 400 - carry
   localparam int QUART_W   = 13;   // shifted year / 4
   localparam int QUOT_W    = 8;    // dividend / 25
   localparam int SUM_W     = 15;   // weekday sum before mod 7
   localparam int REQ_W     = 24;
   localparam int RSP_W     = 24;

   // floor(x / 25) == (x * 5243) >> 17 for every x below 43690
   localparam int           RECIP_SHIFT = 17;
   localparam logic [12:0]  RECIP25     = 13'd5243;

   localparam logic [MONTH_W-1:0] FEB        = 4'd2;
   localparam logic [WDAY_W-1:0]  WD_FRIDAY  = 3'd5;
   localparam logic [WDAY_W-1:0]  WD_SATURDAY = 3'd6;

   // First member lands in the highest bits, so year sits at the bottom.
   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } gdf_req_type;

   // First member lands in the highest bits.
   typedef struct packed {
      logic [DOY_W-1:0]   days_to_year_end;
      logic [DIM_W-1:0]   days_to_month_end;
      logic [WDAY_W-1:0]  days_to_week_end;
      logic               is_business_day;
      logic               is_weekend;
      logic               is_end_of_week;
      logic [WDAY_W-1:0]  weekday;
      logic               date_valid;
   } gdf_rsp_type;

   // Length of month; zero for a month code outside January..December.
   function automatic logic [DIM_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DIM_W-1:0] r;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
         FEB:                                        r = leap ? 5'd29 : 5'd28;
         default:                                    r = 5'd0;
      endcase
      return r;
   endfunction

   // Days before the first of the month in a common year.
   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] r;
      unique case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // (31 * shifted_month) / 12, shifted months run March = 1 .. February = 12.
   function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] r;
      unique case (m)
         4'd1:    r = 5'd28;
         4'd2:    r = 5'd31;
         4'd3:    r = 5'd2;
         4'd4:    r = 5'd5;
         4'd5:    r = 5'd7;
         4'd6:    r = 5'd10;
         4'd7:    r = 5'd12;
         4'd8:    r = 5'd15;
         4'd9:    r = 5'd18;
         4'd10:   r = 5'd20;
         4'd11:   r = 5'd23;
         4'd12:   r = 5'd25;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> src/gdf_div25.sv
`default_nettype none

module gdf_div25 (
   input  wire logic [gdf_pkg::QUART_W-1:0] dividend,
   output logic [gdf_pkg::QUOT_W-1:0]       quotient
);
   import gdf_pkg::*;

   logic [24:0] product;

   // reciprocal multiply, exact for every dividend below 6400 (the shifted
   // year over four never exceeds 4196)
   assign product  = 25'(dividend) * 25'(RECIP25);
   assign quotient = product[RECIP_SHIFT +: QUOT_W];

endmodule

`default_nettype wire

>>> src/gregorian_date_facts_top.sv
`default_nettype none

// Gregorian date facts: each request carries one date (year, month, day) and
// yields exactly one response with the weekday (Sunday = 0), the end-of-week,
// weekend (Friday or Saturday) and business-day flags, the days left in the
// week, and the days left to month end and year end, both counting the end
// day itself. A month or day out of range gives date_valid low and every
// other field zero. Years are taken over the full 14-bit range with the
// Gregorian leap rule. The block keeps no state between requests. It takes a
// request every cycle while the response is not stalled; each response passes
// the three register stages of the pipeline (divide by 25, weekday sum and
// leap check, mod 7 and counts) before it is offered. Every stage has its own
// valid bit and moves up when the stage ahead has room, so bubbles close up and
// a stalled response still lets earlier stages fill.

module gregorian_date_facts_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: year [13:0], month [17:14], day [22:18], zero [23]
   input  wire logic [23:0] req_tdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // response: date_valid [0], weekday [3:1], is_end_of_week [4],
   // is_weekend [5], is_business_day [6], days_to_week_end [9:7],
   // days_to_month_end [14:10], days_to_year_end [23:15]
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready
);
   import gdf_pkg::*;

   gdf_req_type req;

   // stage readiness, each stage takes new data when empty or draining
   logic ready1, ready2, ready3;

   // ---------------- stage 1: shifted year and divides by 25 ----------------
   logic                v1_ff;
   logic [MONTH_W-1:0]  m1_ff, m1_in;
   logic [DAY_W-1:0]    d1_ff, d1_in;
   logic [1:0]          ylo1_ff, ylo1_in;      // year mod 4
   logic [11:0]         yq1_ff, yq1_in;        // year / 4
   logic [QUOT_W-1:0]   yq25_1_ff, yq25_1_in;  // year / 100
   logic [SHIFT_W-1:0]  yy1_ff, yy1_in;
   logic [QUOT_W-1:0]   q100_1_ff, q100_1_in;  // shifted year / 100

   logic                carry;
   logic [QUART_W-1:0]  yy_quart;

   assign req = gdf_req_type'(req_tdata[REQ_W-2:0]);

   always_comb begin
      // January and February count with the year before
      carry   = (req.month <= FEB);
      yy1_in  = SHIFT_W'(req.year) + SHIFT_W'(400) - SHIFT_W'(carry);
      m1_in   = req.month;
      d1_in   = req.day;
      ylo1_in = req.year[1:0];
      yq1_in  = req.year[YEAR_W-1:2];
   end

   assign yy_quart = yy1_in[SHIFT_W-1:2];

   gdf_div25 u_div_shift (
      .dividend (yy_quart),
      .quotient (q100_1_in)
   );

   gdf_div25 u_div_year (
      .dividend ({1'b0, yq1_in}),
      .quotient (yq25_1_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && req_tvalid) begin
         m1_ff     <= m1_in;
         d1_ff     <= d1_in;
         ylo1_ff   <= ylo1_in;
         yq1_ff    <= yq1_in;
         yq25_1_ff <= yq25_1_in;
         yy1_ff    <= yy1_in;
         q100_1_ff <= q100_1_in;
      end
   end

   // ---------------- stage 2: leap check, month length, weekday sum ---------
   logic                v2_ff;
   logic                ok2_ff, ok2_in;
   logic                leap2_ff, leap2_in;
   logic [DIM_W-1:0]    dim2_ff, dim2_in;
   logic [MONTH_W-1:0]  m2_ff;
   logic [DAY_W-1:0]    d2_ff;
   logic [SUM_W-1:0]    sum2_ff, sum2_in;

   logic [11:0]         rem25;
   logic                div4, div100, div400;

   always_comb begin
      rem25    = yq1_ff - 12'({yq25_1_ff, 4'b0000} + {yq25_1_ff, 3'b000}
                              + 12'(yq25_1_ff));
      div4     = (ylo1_ff == 2'd0);
      div100   = div4 && (rem25 == 12'd0);
      div400   = div100 && (yq25_1_ff[1:0] == 2'd0);
      leap2_in = div400 || (div4 && !div100);
      dim2_in  = month_days(m1_ff, leap2_in);
      ok2_in   = (dim2_in != '0) && (d1_ff != '0) && (d1_ff <= dim2_in);
      sum2_in  = SUM_W'(d1_ff) + SUM_W'(yy1_ff) + SUM_W'(yy1_ff[SHIFT_W-1:2])
               - SUM_W'(q100_1_ff) + SUM_W'(q100_1_ff[QUOT_W-1:2])
               + SUM_W'(month_offset(m1_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ready2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2 && v1_ff) begin
         ok2_ff   <= ok2_in;
         leap2_ff <= leap2_in;
         dim2_ff  <= dim2_in;
         m2_ff    <= m1_ff;
         d2_ff    <= d1_ff;
         sum2_ff  <= sum2_in;
      end
   end

   // ---------------- stage 3: mod 7, counts, response register -------------
   logic                v3_ff;
   gdf_rsp_type         rsp_ff, rsp_in;

   logic [5:0]          fold1;
   logic [3:0]          fold2;
   logic [WDAY_W-1:0]   wday;
   logic [DOY_W-1:0]    doy;
   logic                wkend;

   always_comb begin
      // 8 == 1 mod 7: add up octal digits, twice, then one subtract
      fold1 = 6'(sum2_ff[2:0]) + 6'(sum2_ff[5:3]) + 6'(sum2_ff[8:6])
            + 6'(sum2_ff[11:9]) + 6'(sum2_ff[14:12]);
      fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
      wday  = (fold2 >= 4'd7) ? WDAY_W'(fold2 - 4'd7) : WDAY_W'(fold2);
      wkend = (wday == WD_FRIDAY) || (wday == WD_SATURDAY);
      doy   = days_before(m2_ff) + DOY_W'(d2_ff)
            + DOY_W'(leap2_ff && (m2_ff > FEB));

      rsp_in = '0;
      if (ok2_ff) begin
         rsp_in.date_valid        = 1'b1;
         rsp_in.weekday           = wday;
         rsp_in.is_end_of_week    = (wday == WD_SATURDAY);
         rsp_in.is_weekend        = wkend;
         rsp_in.is_business_day   = !wkend;
         rsp_in.days_to_week_end  = WD_SATURDAY - wday;
         rsp_in.days_to_month_end = dim2_ff - d2_ff + DIM_W'(1);
         rsp_in.days_to_year_end  = DOY_W'(366) + DOY_W'(leap2_ff) - doy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (ready3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready3 && v2_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   // ---------------- handshake ----------------
   assign ready3     = !v3_ff || rsp_tready;
   assign ready2     = !v2_ff || ready3;
   assign ready1     = !v1_ff || ready2;
   assign req_tready = ready1;

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = rsp_ff;

   // top pad bit of the request carries nothing
   logic unused_pad;
   assign unused_pad = req_tdata[REQ_W-1];

endmodule

`default_nettype wire

>>> dv/tb_gregorian_date_facts_top.sv
`timescale 1ns / 1ps

module tb_gregorian_date_facts_top;
   import gdf_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1500;
   localparam int unsigned MAX_IDLE     = 18;
   localparam int unsigned LONG_HOLD    = 300;    // receiver hold-off, in cycles
   localparam int unsigned TAIL_CYCLES  = 12;     // pipeline is three stages deep
   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam int unsigned REPORT_MAX   = 10;

   // Expected-facts store: predicts each accepted request and checks the
   // responses against those predictions in arrival order.
   class date_scoreboard;
      gdf_rsp_type expected_facts[$];
      int unsigned mismatches = 0;

      function bit is_leap(int unsigned yr);
         return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
      endfunction

      // Zero for a month code outside January..December.
      function int unsigned month_length(int unsigned mo, bit leap_yr);
         case (mo)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            FEB:                   return leap_yr ? 29 : 28;
            default:               return 0;
         endcase
      endfunction

      function gdf_rsp_type predict_facts(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                          logic [DAY_W-1:0] d);
         gdf_rsp_type r;
         int unsigned yr, mo, dy, dim, carry, ys, ms, wd, doy, ylen;
         bit          leap_yr;
         r       = '0;
         yr      = y;
         mo      = m;
         dy      = d;
         leap_yr = is_leap(yr);
         dim     = month_length(mo, leap_yr);
         if (dim == 0 || dy < 1 || dy > dim) return r;
         // Shift January and February into the prior year; adding 400 years
         // keeps the weekday and keeps year zero from going negative.
         carry = (mo <= 2) ? 1 : 0;
         ys    = yr + 400 - carry;
         ms    = mo + 12 * carry - 2;
         wd    = (dy + ys + ys / 4 - ys / 100 + ys / 400 + (31 * ms) / 12) % 7;
         doy   = dy;
         for (int unsigned k = 1; k < mo; k++) doy += month_length(k, leap_yr);
         ylen  = leap_yr ? 366 : 365;
         r.date_valid        = 1'b1;
         r.weekday           = wd[WDAY_W-1:0];
         r.is_end_of_week    = (wd == WD_SATURDAY);
         r.is_weekend        = (wd == WD_FRIDAY) || (wd == WD_SATURDAY);
         r.is_business_day   = !r.is_weekend;
         r.days_to_week_end  = 3'(6 - wd);
         r.days_to_month_end = 5'(dim - dy + 1);
         r.days_to_year_end  = 9'(ylen - doy + 1);
         return r;
      endfunction

      function void note_request(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                                 logic [DAY_W-1:0] d);
         expected_facts.push_back(predict_facts(y, m, d));
      endfunction

      function int unsigned pending();
         return expected_facts.size();
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("[%0t] %s mismatch: expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(gdf_rsp_type got);
         gdf_rsp_type want;
         if (expected_facts.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("[%0t] response with nothing outstanding: %h", $time, got);
            return;
         end
         want = expected_facts.pop_front();
         compare_field("date_valid",        want.date_valid,        got.date_valid);
         compare_field("weekday",           want.weekday,           got.weekday);
         compare_field("is_end_of_week",    want.is_end_of_week,    got.is_end_of_week);
         compare_field("is_weekend",        want.is_weekend,        got.is_weekend);
         compare_field("is_business_day",   want.is_business_day,   got.is_business_day);
         compare_field("days_to_week_end",  want.days_to_week_end,  got.days_to_week_end);
         compare_field("days_to_month_end", want.days_to_month_end, got.days_to_month_end);
         compare_field("days_to_year_end",  want.days_to_year_end,  got.days_to_year_end);
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic [23:0] req_tdata   = '0;   // year [13:0], month [17:14], day [22:18], zero [23]
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   // date_valid [0], weekday [3:1], is_end_of_week [4], is_weekend [5],
   // is_business_day [6], days_to_week_end [9:7], days_to_month_end [14:10],
   // days_to_year_end [23:15]
   logic [23:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;

   date_scoreboard sb;
   bit             req_calm          = 1'b0;  // sender offers back to back
   bit             long_hold_pending = 1'b0;  // ask the receiver for a long hold-off
   int unsigned    cycle_count       = 0;

   gregorian_date_facts_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Drop the run once it has gone far beyond the slowest legal schedule.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Check every response accepted at this edge against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(gdf_rsp_type'(rsp_tdata));
   end

   // Offer one request after a random gap and hold it until accepted. Keep
   // tvalid high across back-to-back requests so it is never lowered and
   // raised in the same step.
   task automatic offer_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                             input logic [DAY_W-1:0] d);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {1'b0, d, m, y};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(y, m, d);
   endtask

   // Pause the sender until every outstanding request has its response.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Receiver: stall a random number of cycles before each response, with
   // calm stretches of no stalling, and one long hold-off on request.
   initial begin : rsp_side
      int unsigned stall;
      int unsigned taken;
      bit          rsp_calm;
      taken    = 0;
      rsp_calm = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 64 == 0) rsp_calm = ($urandom_range(0, 2) == 0);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            stall = rsp_calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   initial begin : req_side
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Leap-day handling: leap, common, century and 400-year cases, year zero.
      offer_date(14'd2024, 4'd2, 5'd29);
      offer_date(14'd2023, 4'd2, 5'd29);
      offer_date(14'd1900, 4'd2, 5'd29);
      offer_date(14'd2000, 4'd2, 5'd29);
      offer_date(14'd0,    4'd2, 5'd29);
      offer_date(14'd0,    4'd1, 5'd1);
      // Year extremes, inside and beyond the calendar range.
      offer_date(14'd1,     4'd1,  5'd1);
      offer_date(14'd9999,  4'd12, 5'd31);
      offer_date(14'd10000, 4'd7,  5'd4);
      offer_date(14'd16383, 4'd12, 5'd31);
      offer_date(14'd16383, 4'd15, 5'd31);
      // Month and day out of range: everything must read zero.
      offer_date(14'd2024, 4'd0,  5'd10);
      offer_date(14'd2024, 4'd13, 5'd1);
      offer_date(14'd2024, 4'd4,  5'd31);
      offer_date(14'd2024, 4'd1,  5'd0);
      offer_date(14'd2024, 4'd2,  5'd30);
      // Month and year edges, inclusive counts.
      offer_date(14'd2024, 4'd4,  5'd30);
      offer_date(14'd2024, 4'd12, 5'd31);
      offer_date(14'd2023, 4'd1,  5'd1);
      offer_date(14'd2024, 4'd1,  5'd1);
      offer_date(14'd2024, 4'd3,  5'd1);
      // A Friday, a Saturday and a Sunday in a row.
      offer_date(14'd2025, 4'd6, 5'd6);
      offer_date(14'd2025, 4'd6, 5'd7);
      offer_date(14'd2025, 4'd6, 5'd8);
      drain_responses();

      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) req_calm = ($urandom_range(0, 3) == 0);
         // Hold the receiver off while requests stream in back to back, so the
         // pipeline fills and stalls its input.
         if (n == 300) long_hold_pending = 1'b1;
         if (n >= 300 && n < 420) req_calm = 1'b1;
         if (n == 800 || n == 1200) drain_responses();
         y = 14'($urandom_range(0, 16383));
         if ($urandom_range(0, 3) != 0) begin
            m = 4'($urandom_range(1, 12));
            d = 5'($urandom_range(1, sb.month_length(m, sb.is_leap(y))));
         end else begin
            m = 4'($urandom_range(0, 15));
            d = 5'($urandom_range(0, 31));
         end
         offer_date(y, m, d);
      end
      req_tvalid <= 1'b0;

      // Wait out the remaining responses, then watch for strays.
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
src/gdf_pkg.sv
src/gdf_div25.sv
src/gregorian_date_facts_top.sv
dv/tb_gregorian_date_facts_top.sv
